>>> rtl/core/ffd_pkg.sv
package ffd_pkg;

	// fnv-1a 64 prime and a nonstandard start value for the hash
	localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;
	localparam logic [63:0] FNV_PRIME = 64'd1099511628211;

	// pixel and byte layout
	localparam int PIXEL_W = 32;
	localparam int BYTE_W = 8;
	localparam int BYTES_PER_PIXEL = PIXEL_W / BYTE_W;
	localparam int HASH_W = 64;
	localparam int REG_W = 16;
	localparam int OUT_CNT_W = 16;

	// result status codes
	localparam logic [1:0] STATUS_CONTINUE = 2'd0;
	localparam logic [1:0] STATUS_STABLE = 2'd1;
	localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

	// register indexes
	localparam logic CFG_STALE_LIMIT = 1'b0;
	localparam logic CFG_TIMEOUT_FRAMES = 1'b1;

	// control from the frame logic to the byte hasher
	typedef struct packed {
		logic start;
		logic clear;
	} hash_ctl_t;

	// one fnv-1a byte step; the prime is 2^40 + 2^8 + 0xb3, so the
	// multiply is a sum of shifted copies
	function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
			input logic [BYTE_W-1:0] b);
		logic [HASH_W-1:0] x;
		x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4)
			+ (x << 1) + x;
	endfunction

endpackage

>>> rtl/core/ffd_if.sv
interface ffd_pixel_if;
	logic valid;
	logic ready;
	logic [ffd_pkg::PIXEL_W-1:0] pixel;
	logic frame_end;
	logic restart;

	modport source (output valid, pixel, frame_end, restart, input ready);
	modport sink (input valid, pixel, frame_end, restart, output ready);
endinterface

interface ffd_result_if;
	logic valid;
	logic ready;
	logic [ffd_pkg::HASH_W-1:0] frame_hash;
	logic [ffd_pkg::OUT_CNT_W-1:0] stale_count;
	logic [ffd_pkg::OUT_CNT_W-1:0] frames_waited;
	logic [1:0] status;

	modport source (output valid, frame_hash, stale_count, frames_waited, status,
		input ready);
	modport sink (input valid, frame_hash, stale_count, frames_waited, status,
		output ready);
endinterface

>>> rtl/core/ffd_hasher.sv
module ffd_hasher (
	input  logic clk,
	input  logic arst_n,
	input  ffd_pkg::hash_ctl_t ctl,
	input  logic [ffd_pkg::PIXEL_W-1:0] pixel,
	output logic done,
	output logic [ffd_pkg::HASH_W-1:0] hash
);

	localparam int CNT_W = $clog2(ffd_pkg::BYTES_PER_PIXEL);
	localparam logic [CNT_W-1:0] LAST_BYTE = CNT_W'(ffd_pkg::BYTES_PER_PIXEL - 1);

	logic [ffd_pkg::PIXEL_W-1:0] pix_q;
	logic [CNT_W-1:0] byte_cnt_q;
	logic busy_q;
	logic [ffd_pkg::HASH_W-1:0] hash_q;

	// last byte step of the word happens this cycle
	assign done = busy_q && (byte_cnt_q == LAST_BYTE);
	assign hash = hash_q;

	// byte shift register and running hash, low byte first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			byte_cnt_q <= '0;
			hash_q <= ffd_pkg::FNV_BASIS;
		end else begin
			if (ctl.start) begin
				busy_q <= 1'b1;
				byte_cnt_q <= '0;
			end else if (busy_q) begin
				hash_q <= ffd_pkg::fnv_step(hash_q, pix_q[ffd_pkg::BYTE_W-1:0]);
				byte_cnt_q <= byte_cnt_q + CNT_W'(1);
				if (byte_cnt_q == LAST_BYTE)
					busy_q <= 1'b0;
			end else if (ctl.clear) begin
				hash_q <= ffd_pkg::FNV_BASIS;
			end
		end
	end

	// payload shift register
	always_ff @(posedge clk) begin
		if (ctl.start)
			pix_q <= pixel;
		else if (busy_q)
			pix_q <= pix_q >> ffd_pkg::BYTE_W;
	end

endmodule

>>> rtl/core/frame_freeze_detector.sv
// Frame freeze detector: folds each 32-bit pixel word into a 64-bit FNV-1a
// style hash one byte per cycle, low byte first, through a byte shift register.
// Ready stays low from the acceptance of a word until its four byte steps are
// done; a word that ends a frame then passes a compare state that loads the
// result register, and waits there only while the previous result has not been
// taken. The result register separates the output from the input, so a pending
// result does not block new pixels except at the next frame end. With a nonzero
// stale limit, the first frame after reset or restart primes the stored hash;
// stable (status 1) wins over timeout (status 2). Counters are COUNT_WIDTH bits
// and saturate; reported counts clamp at 65535.
module frame_freeze_detector #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	ffd_pixel_if.sink pixels,
	ffd_result_if.source results,
	input  logic cfg_wr_en,
	input  logic cfg_index,
	input  logic [ffd_pkg::REG_W-1:0] cfg_data
);

	localparam int MW = (COUNT_WIDTH > ffd_pkg::OUT_CNT_W) ? COUNT_WIDTH
		: ffd_pkg::OUT_CNT_W;
	localparam logic [MW-1:0] OUT_MAX = MW'({ffd_pkg::OUT_CNT_W{1'b1}});
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	typedef enum logic [1:0] {S_IDLE, S_HASH, S_FIN} state_t;

	state_t state_q;
	logic [ffd_pkg::REG_W-1:0] stale_limit_q;
	logic [ffd_pkg::REG_W-1:0] timeout_q;
	logic [ffd_pkg::HASH_W-1:0] prev_hash_q;
	logic primed_q;
	logic [COUNT_WIDTH-1:0] stale_cnt_q;
	logic [COUNT_WIDTH-1:0] wait_cnt_q;
	logic frame_end_q;
	logic out_valid_q;
	logic [ffd_pkg::HASH_W-1:0] out_hash_q;
	logic [ffd_pkg::OUT_CNT_W-1:0] out_stale_q;
	logic [ffd_pkg::OUT_CNT_W-1:0] out_wait_q;
	logic [1:0] out_status_q;

	ffd_pkg::hash_ctl_t hash_ctl;
	logic hash_done;
	logic [ffd_pkg::HASH_W-1:0] hash;
	logic accept;
	logic out_free;
	logic fin_go;

	logic [COUNT_WIDTH-1:0] wait_nx;
	logic [COUNT_WIDTH-1:0] stale_nx;
	logic [ffd_pkg::HASH_W-1:0] prev_nx;
	logic primed_nx;
	logic stable;
	logic [1:0] status_nx;

	function automatic logic [ffd_pkg::OUT_CNT_W-1:0] clamp_out(
			input logic [COUNT_WIDTH-1:0] v);
		logic [MW-1:0] ext;
		ext = MW'(v);
		return (ext > OUT_MAX) ? {ffd_pkg::OUT_CNT_W{1'b1}}
			: ext[ffd_pkg::OUT_CNT_W-1:0];
	endfunction

	// handshakes
	assign pixels.ready = (state_q == S_IDLE);
	assign accept = pixels.valid && pixels.ready;
	assign out_free = !out_valid_q || results.ready;
	assign fin_go = (state_q == S_FIN) && out_free;

	assign hash_ctl.start = accept;
	assign hash_ctl.clear = fin_go;

	ffd_hasher u_hasher (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(hash_ctl),
		.pixel(pixels.pixel),
		.done(hash_done),
		.hash(hash)
	);

	// frame-end update of tracker and counters
	always_comb begin
		wait_nx = (wait_cnt_q == CNT_MAX) ? wait_cnt_q : wait_cnt_q + COUNT_WIDTH'(1);
		stale_nx = stale_cnt_q;
		prev_nx = prev_hash_q;
		primed_nx = primed_q;
		stable = 1'b0;
		if (stale_limit_q != '0) begin
			if (!primed_q) begin
				primed_nx = 1'b1;
				prev_nx = hash;
				stale_nx = '0;
			end else begin
				if (hash == prev_hash_q) begin
					stale_nx = (stale_cnt_q == CNT_MAX) ? stale_cnt_q
						: stale_cnt_q + COUNT_WIDTH'(1);
				end else begin
					prev_nx = hash;
					stale_nx = '0;
				end
				stable = MW'(stale_nx) >= MW'(stale_limit_q);
			end
		end
		if (stable)
			status_nx = ffd_pkg::STATUS_STABLE;
		else if (timeout_q != '0 && MW'(wait_nx) >= MW'(timeout_q))
			status_nx = ffd_pkg::STATUS_TIMEOUT;
		else
			status_nx = ffd_pkg::STATUS_CONTINUE;
	end

	// sequencer, configuration and tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stale_limit_q <= '0;
			timeout_q <= '0;
			prev_hash_q <= '0;
			primed_q <= 1'b0;
			stale_cnt_q <= '0;
			wait_cnt_q <= '0;
			frame_end_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					ffd_pkg::CFG_STALE_LIMIT: stale_limit_q <= cfg_data;
					ffd_pkg::CFG_TIMEOUT_FRAMES: timeout_q <= cfg_data;
					default: ;
				endcase
			end
			if (results.ready && !fin_go)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						frame_end_q <= pixels.frame_end;
						if (pixels.restart) begin
							primed_q <= 1'b0;
							prev_hash_q <= '0;
							stale_cnt_q <= '0;
							wait_cnt_q <= '0;
						end
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (hash_done)
						state_q <= frame_end_q ? S_FIN : S_IDLE;
				end
				S_FIN: begin
					if (out_free) begin
						wait_cnt_q <= wait_nx;
						stale_cnt_q <= stale_nx;
						prev_hash_q <= prev_nx;
						primed_q <= primed_nx;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_hash_q <= hash;
			out_stale_q <= clamp_out(stale_nx);
			out_wait_q <= clamp_out(wait_nx);
			out_status_q <= status_nx;
		end
	end

	assign results.valid = out_valid_q;
	assign results.frame_hash = out_hash_q;
	assign results.stale_count = out_stale_q;
	assign results.frames_waited = out_wait_q;
	assign results.status = out_status_q;

endmodule
